// File: hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// Linear congruence solver package
// Shared widths, status codes and the request and response beat types.
// ----------------------------------------------------------------------------
package lcs_pkg;

   localparam int WIDTH    = 32;
   localparam int FW       = WIDTH - 1;
   localparam int CNT_W    = $clog2(WIDTH);

   localparam logic [1:0] STATUS_UNIQUE  = 2'd0;
   localparam logic [1:0] STATUS_SEVERAL = 2'd1;
   localparam logic [1:0] STATUS_NONE    = 2'd2;

   typedef struct packed {
      logic signed [WIDTH-1:0] coefficient;
      logic [FW-1:0]           right_side;
      logic [FW-1:0]           modulus;
   } req_type;

   typedef struct packed {
      logic [1:0]    status;
      logic [FW-1:0] divisor;
      logic [FW-1:0] inverse;
      logic [FW-1:0] first_solution;
      logic [FW-1:0] solution_step;
      logic [FW-1:0] solution_count;
   } rsp_type;

endpackage

// File: hdl/linear_congruence_solver.sv
// ----------------------------------------------------------------------------
// Linear congruence solver
// Solves a*x = b (mod m) with the extended Euclidean algorithm on one shared
// bit-serial divider, and reports gcd, inverse, first solution, step, count.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Busy then stays high
// while the item is solved. It drops in the same cycle that the result beat
// appears on rsp_data with rsp_valid high, so a new beat can be taken in that
// cycle. The receiver cannot stall, so it must take the result in that cycle.
// All divisions run through one restoring divider that yields one quotient
// bit per cycle. Each Euclid step passes through a check state before its
// division. An item takes one reduction division, one division per Euclid
// step (up to about 46 steps for 31-bit values), four more divisions and a
// shift-and-add modular multiply. When b is not a multiple of the divisor,
// the item ends after the second of those four divisions. A zero modulus
// is answered as "no solution" from the idle state; busy never rises for it.
module linear_congruence_solver (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  lcs_pkg::req_type req_data,
   output logic            rsp_valid,
   output lcs_pkg::rsp_type rsp_data
);
   import lcs_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_RED, ST_EUC_CHK, ST_EUC_DIV, ST_STEP,
      ST_BDIV, ST_SRED, ST_BRED, ST_MUL
   } state_type;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(WIDTH - 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FW - 1);

   state_type state_ff;

   // Operand and result registers of the item being solved.
   logic [FW-1:0]        b_ff, m_ff, r0_ff, r1_ff, g_ff, step_ff, bq_ff, sred_ff;
   logic                 neg_ff;
   logic signed [WIDTH:0] s0_ff, s1_ff;

   // Shared divider: the quotient bits also drive a multiply of q by |s1|.
   logic [WIDTH-1:0]     div_num_ff, div_rem_ff, div_quo_ff;
   logic [FW-1:0]        div_den_ff;
   logic [WIDTH+1:0]     mac_ff;
   logic [CNT_W-1:0]     cnt_ff;

   // Modular multiply registers.
   logic [FW-1:0]        mm_acc_ff, mm_x_ff, mm_y_ff;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [WIDTH-1:0]     rem_sh, rem_in, quo_in;
   logic                 ge;
   logic [WIDTH+1:0]     mac_in;
   logic signed [WIDTH:0] s1_neg, s0_neg, s1_in;
   logic [FW-1:0]        s1_mag;
   logic [WIDTH-1:0]     s0_mag, a_mag;
   logic [FW-1:0]        rem_lo, room, sum_ax, x2;
   logic [FW-1:0]        ar, sred, mm_final;

   always_comb begin
      rem_sh = {div_rem_ff[WIDTH-2:0], div_num_ff[WIDTH-1]};
      ge     = rem_sh >= {1'b0, div_den_ff};
      rem_in = ge ? rem_sh - {1'b0, div_den_ff} : rem_sh;
      quo_in = {div_quo_ff[WIDTH-2:0], ge};
      rem_lo = rem_in[FW-1:0];

      s1_neg = -s1_ff;
      s0_neg = -s0_ff;
      s1_mag = s1_ff[WIDTH] ? s1_neg[FW-1:0] : s1_ff[FW-1:0];
      s0_mag = s0_ff[WIDTH] ? s0_neg[WIDTH-1:0] : s0_ff[WIDTH-1:0];
      mac_in = {mac_ff[WIDTH:0], 1'b0} + (ge ? {3'b000, s1_mag} : '0);
      s1_in  = s1_ff[WIDTH] ? s0_ff + $signed(mac_in[WIDTH:0])
                            : s0_ff - $signed(mac_in[WIDTH:0]);

      a_mag  = -req_data.coefficient;

      ar   = (neg_ff && rem_lo != '0) ? m_ff - rem_lo : rem_lo;
      sred = (s0_ff[WIDTH] && rem_lo != '0) ? step_ff - rem_lo : rem_lo;

      // (acc + x) mod n and (x + x) mod n, all values below n.
      room     = step_ff - mm_x_ff;
      sum_ax   = (mm_acc_ff >= room) ? mm_acc_ff - room : mm_acc_ff + mm_x_ff;
      x2       = (mm_x_ff >= room) ? mm_x_ff - room : mm_x_ff + mm_x_ff;
      mm_final = mm_y_ff[0] ? sum_ax : mm_acc_ff;
   end

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         // Divider and multiply-accumulate advance every cycle; states that
         // start a new division overwrite them below.
         div_num_ff <= {div_num_ff[WIDTH-2:0], 1'b0};
         div_rem_ff <= rem_in;
         div_quo_ff <= quo_in;
         mac_ff     <= mac_in;
         cnt_ff     <= cnt_ff + 1'b1;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  b_ff   <= req_data.right_side;
                  m_ff   <= req_data.modulus;
                  neg_ff <= req_data.coefficient[WIDTH-1];
                  if (req_data.modulus == '0) begin
                     rsp_ff.status         <= STATUS_NONE;
                     rsp_ff.divisor        <= '0;
                     rsp_ff.inverse        <= '0;
                     rsp_ff.first_solution <= '0;
                     rsp_ff.solution_step  <= '0;
                     rsp_ff.solution_count <= '0;
                     rsp_valid_ff          <= 1'b1;
                  end else begin
                     div_num_ff <= req_data.coefficient[WIDTH-1] ? a_mag
                                                                 : req_data.coefficient;
                     div_den_ff <= req_data.modulus;
                     div_rem_ff <= '0;
                     div_quo_ff <= '0;
                     mac_ff     <= '0;
                     cnt_ff     <= '0;
                     state_ff   <= ST_RED;
                  end
               end
            end
            ST_RED: begin
               if (cnt_ff == DIV_LAST) begin
                  r0_ff    <= ar;
                  r1_ff    <= m_ff;
                  s0_ff    <= (WIDTH+1)'(1);
                  s1_ff    <= '0;
                  state_ff <= ST_EUC_CHK;
               end
            end
            ST_EUC_CHK: begin
               div_rem_ff <= '0;
               div_quo_ff <= '0;
               mac_ff     <= '0;
               cnt_ff     <= '0;
               if (r1_ff == '0) begin
                  g_ff       <= r0_ff;
                  div_num_ff <= {1'b0, m_ff};
                  div_den_ff <= r0_ff;
                  state_ff   <= ST_STEP;
               end else begin
                  div_num_ff <= {1'b0, r0_ff};
                  div_den_ff <= r1_ff;
                  state_ff   <= ST_EUC_DIV;
               end
            end
            ST_EUC_DIV: begin
               if (cnt_ff == DIV_LAST) begin
                  r0_ff    <= r1_ff;
                  r1_ff    <= rem_lo;
                  s0_ff    <= s1_ff;
                  s1_ff    <= s1_in;
                  state_ff <= ST_EUC_CHK;
               end
            end
            ST_STEP: begin
               if (cnt_ff == DIV_LAST) begin
                  step_ff    <= quo_in[FW-1:0];
                  div_num_ff <= {1'b0, b_ff};
                  div_den_ff <= g_ff;
                  div_rem_ff <= '0;
                  div_quo_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_BDIV;
               end
            end
            ST_BDIV: begin
               if (cnt_ff == DIV_LAST) begin
                  if (rem_lo != '0) begin
                     rsp_ff.status         <= STATUS_NONE;
                     rsp_ff.divisor        <= g_ff;
                     rsp_ff.inverse        <= '0;
                     rsp_ff.first_solution <= '0;
                     rsp_ff.solution_step  <= step_ff;
                     rsp_ff.solution_count <= '0;
                     rsp_valid_ff          <= 1'b1;
                     state_ff              <= ST_IDLE;
                  end else begin
                     bq_ff      <= quo_in[FW-1:0];
                     div_num_ff <= s0_mag;
                     div_den_ff <= step_ff;
                     div_rem_ff <= '0;
                     div_quo_ff <= '0;
                     cnt_ff     <= '0;
                     state_ff   <= ST_SRED;
                  end
               end
            end
            ST_SRED: begin
               if (cnt_ff == DIV_LAST) begin
                  sred_ff    <= sred;
                  div_num_ff <= {1'b0, bq_ff};
                  div_den_ff <= step_ff;
                  div_rem_ff <= '0;
                  div_quo_ff <= '0;
                  cnt_ff     <= '0;
                  state_ff   <= ST_BRED;
               end
            end
            ST_BRED: begin
               if (cnt_ff == DIV_LAST) begin
                  mm_x_ff   <= sred_ff;
                  mm_y_ff   <= rem_lo;
                  mm_acc_ff <= '0;
                  cnt_ff    <= '0;
                  state_ff  <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (mm_y_ff[0]) begin
                  mm_acc_ff <= sum_ax;
               end
               mm_x_ff <= x2;
               mm_y_ff <= {1'b0, mm_y_ff[FW-1:1]};
               if (cnt_ff == MUL_LAST) begin
                  rsp_ff.status <= (g_ff == FW'(1)) ? STATUS_UNIQUE : STATUS_SEVERAL;
                  rsp_ff.divisor        <= g_ff;
                  rsp_ff.inverse        <= (g_ff == FW'(1)) ? sred_ff : '0;
                  rsp_ff.first_solution <= mm_final;
                  rsp_ff.solution_step  <= step_ff;
                  rsp_ff.solution_count <= g_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sim/lcs_checker.sv
// ----------------------------------------------------------------------------
// Linear congruence solver checker
// Watches request and response beats, computes the expected solution of each
// accepted congruence and compares each response beat with it, printing the fields on a mismatch.
// ----------------------------------------------------------------------------
module lcs_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  lcs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  lcs_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending
);
   import lcs_pkg::*;

   rsp_type solutions_due[$];

   function automatic longint unsigned wrap_signed(longint s, longint unsigned n);
      longint unsigned mag;
      if (s >= 0) return longint'(s) % n;
      mag = longint'(-s) % n;
      return (mag == 0) ? 0 : n - mag;
   endfunction

   function automatic rsp_type solve_congruence(req_type rq);
      rsp_type r;
      longint unsigned m, b, ar, r0, r1, q, rem, g, step, sr, bb, acc;
      longint s0, s1, sn;
      longint signed_a;
      r = '0;
      m = rq.modulus;
      b = rq.right_side;
      if (m == 0) begin
         r.status = STATUS_NONE;
         return r;
      end
      signed_a = $signed(rq.coefficient);
      ar = wrap_signed(signed_a, m);
      r0 = ar; r1 = m; s0 = 1; s1 = 0;
      while (r1 != 0) begin
         q = r0 / r1;
         rem = r0 - q * r1;
         sn = s0 - longint'(q) * s1;
         r0 = r1; r1 = rem; s0 = s1; s1 = sn;
      end
      g = r0;
      step = m / g;
      r.divisor = g[FW-1:0];
      r.solution_step = step[FW-1:0];
      if (g == 1) r.inverse = FW'(wrap_signed(s0, m));
      if (b % g != 0) begin
         r.status = STATUS_NONE;
         return r;
      end
      sr = wrap_signed(s0, step);
      bb = (b / g) % step;
      acc = (sr * bb) % step;  // both below 2^31, product fits
      r.first_solution = acc[FW-1:0];
      r.solution_count = g[FW-1:0];
      r.status = (g == 1) ? STATUS_UNIQUE : STATUS_SEVERAL;
      return r;
   endfunction

   assign pending = solutions_due.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         error_count <= 0;
      end else begin
         if (start && !busy) solutions_due.push_back(solve_congruence(req_data));
         if (rsp_valid) begin
            if (solutions_due.size() == 0) begin
               if (error_count < 10) $display("unexpected response beat %h", rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = solutions_due.pop_front();
               if (want !== rsp_data) begin
                  if (error_count < 10) begin
                     $write("mismatch: exp st=%0d g=%0d inv=%0d x=%0d step=%0d n=%0d, ",
                        want.status, want.divisor, want.inverse, want.first_solution,
                        want.solution_step, want.solution_count);
                     $display("got st=%0d g=%0d inv=%0d x=%0d step=%0d n=%0d",
                        rsp_data.status, rsp_data.divisor, rsp_data.inverse,
                        rsp_data.first_solution, rsp_data.solution_step,
                        rsp_data.solution_count);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Linear congruence solver testbench
// Drives directed and random congruences with random gaps; the checker
// predicts each answer and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import lcs_pkg::*;

   // The block has no stall input on the response side, so only the
   // request side idles. The watchdog limit covers the worst item plus a long gap.
   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count;
   int      pending;
   int      idle_cycles = 0;

   always #5 clock = ~clock;

   linear_congruence_solver DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   lcs_checker lcs_checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .error_count(error_count), .pending(pending)
   );

   // The watchdog counts cycles without any accepted beat.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Most gaps are short, a few long.
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
      repeat (n) @(posedge clock);
   endtask

   // Present one beat and hold start until the block takes it. Start then goes
   // low across a clock edge, so the next beat is driven at a later edge.
   task automatic send_beat(logic [31:0] a, logic [30:0] b, logic [30:0] m);
      req_data <= '{coefficient: a, right_side: b, modulus: m};
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      start <= 1'b0;
      @(posedge clock);
   endtask

   // Half of the moduli are small or products, so common divisors show up often.
   function automatic logic [30:0] pick_modulus();
      case ($urandom_range(0, 5))
         0: return 31'($urandom_range(1, 16));
         1: return 31'($urandom_range(1, 1000));
         2: return 31'($urandom_range(1, 1 << 10)) * 31'($urandom_range(1, 1 << 10));
         3: return 31'h7fffffff;
         4: return 31'($urandom_range(0, 30) == 0 ? 0 : $urandom);
         default: return 31'($urandom);
      endcase
   endfunction

   initial begin
      logic [30:0] m, g;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes and the special cases named in the header.
      send_beat(32'h0, 31'h0, 31'd1);                 // modulus one
      send_beat(32'h7fffffff, 31'h7fffffff, 31'd1);
      send_beat(32'h80000000, 31'd5, 31'd1);
      send_beat(32'h0, 31'd0, 31'd7);                 // coefficient zero, m divides b
      send_beat(32'h0, 31'd3, 31'd7);                 // coefficient zero, no solution
      send_beat(32'd7, 31'd14, 31'd7);                // a equals m
      send_beat(32'hfffffff9, 31'd0, 31'd7);          // a equals -m
      send_beat(32'd5, 31'd3, 31'd0);                 // modulus zero
      send_beat(32'h80000000, 31'h7fffffff, 31'h7fffffff);
      send_beat(32'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      send_beat(32'hffffffff, 31'h0, 31'h7fffffff);
      send_beat(32'd3, 31'd1, 31'd10);                // unique inverse
      send_beat(32'd6, 31'd4, 31'd10);                // several solutions
      send_beat(32'd6, 31'd5, 31'd10);                // no solution
      send_beat(32'hfffffffa, 31'd8, 31'd10);         // negative coefficient
      send_beat(32'h4b3d2a11, 31'h6a5b4c3d, 31'h40000000);
      send_beat(32'd1836311903, 31'd1, 31'd1134903170); // long Euclid chain
      send_beat(32'h55555555, 31'h2aaaaaaa, 31'h55555555);

      // Pause until every expected result has come.
      while (pending != 0) @(posedge clock);

      for (int i = 0; i < 370; i++) begin
         if (i == 185) while (pending != 0) @(posedge clock);
         if ($urandom_range(0, 3) != 0) idle_gap();
         m = pick_modulus();
         if ($urandom_range(0, 2) == 0 && m > 1) begin
            // Coefficient a multiple of a small g (or its bitwise inverse) and b a multiple of g.
            g = 31'($urandom_range(1, 64));
            send_beat(32'(g * 31'($urandom_range(0, 1 << 20))) ^
                      ($urandom_range(0, 1) ? 32'hffffffff : 32'h0),
                      31'(g * 31'($urandom_range(0, 1 << 24))), m);
         end else begin
            send_beat($urandom, 31'($urandom), m);
         end
      end

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
